### hdl/tsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg
// shared widths, header field offsets, region codes and entry kind decode
// for the tar stream deframer
// ----------------------------------------------------------------------------
package tsd_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 9;
	localparam int SIZE_W = 36;
	localparam int MODE_W = 24;
	localparam int KIND_W = 3;
	localparam int ZCNT_W = 2;

	localparam logic [POS_W-1:0] MODE_FIRST = POS_W'(100);
	localparam logic [POS_W-1:0] MODE_LAST  = POS_W'(107);
	localparam logic [POS_W-1:0] SIZE_FIRST = POS_W'(124);
	localparam logic [POS_W-1:0] SIZE_LAST  = POS_W'(135);
	localparam logic [POS_W-1:0] TYPE_POS   = POS_W'(156);
	localparam logic [POS_W-1:0] BLOCK_LAST = POS_W'(511);

	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_FIVE  = 8'h35;
	localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd48;

	localparam logic [ZCNT_W-1:0] ZERO_BLOCKS_TO_END = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ZERO_BLOCK = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OTHER      = 3'd7;

	typedef enum logic [1:0] {
		RGN_HEADER = 2'd0,
		RGN_DATA   = 2'd1,
		RGN_PAD    = 2'd2,
		RGN_END    = 2'd3
	} region_t;

	typedef struct packed {
		logic             feed;
		logic             clear;
		logic [POS_W-1:0] pos;
	} hdr_ctl_t;

	function automatic logic [KIND_W-1:0] kind_of(input logic [BYTE_W-1:0] t);
		if (t == CHAR_NUL)
			return KIND_ZERO_BLOCK;
		else if (t inside {[CHAR_ZERO:CHAR_FIVE]})
			return KIND_W'(t - CHAR_ZERO) + KIND_W'(1);
		else
			return KIND_OTHER;
	endfunction

endpackage
`default_nettype wire

### hdl/tsd_hdr_fields.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_hdr_fields
// octal shift-add decode of the mode and size fields and capture of the
// type byte while a header block streams past
// ----------------------------------------------------------------------------
module tsd_hdr_fields (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tsd_pkg::hdr_ctl_t          ctl,
	input  wire logic [tsd_pkg::BYTE_W-1:0] data,
	output logic      [tsd_pkg::SIZE_W-1:0] size_acc,
	output logic      [tsd_pkg::MODE_W-1:0] mode_acc,
	output logic      [tsd_pkg::BYTE_W-1:0] type_byte
);
	import tsd_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [MODE_W-1:0] mode_q;
	logic [BYTE_W-1:0] type_q;
	logic              size_stop_q;
	logic              mode_stop_q;
	logic              is_term;
	logic              in_mode;
	logic              in_size;
	logic [SIZE_W-1:0] size_next;
	logic [MODE_W-1:0] mode_next;

	always_comb begin
		is_term   = (data == CHAR_NUL) || (data == CHAR_SPACE);
		in_mode   = ctl.pos inside {[MODE_FIRST:MODE_LAST]};
		in_size   = ctl.pos inside {[SIZE_FIRST:SIZE_LAST]};
		size_next = {size_q[SIZE_W-4:0], 3'b000} + SIZE_W'(data) - SIZE_W'(DIGIT_BASE);
		mode_next = {mode_q[MODE_W-4:0], 3'b000} + MODE_W'(data) - MODE_W'(DIGIT_BASE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			mode_q      <= '0;
			type_q      <= '0;
			size_stop_q <= 1'b0;
			mode_stop_q <= 1'b0;
		end else if (ctl.clear) begin
			size_q      <= '0;
			mode_q      <= '0;
			type_q      <= '0;
			size_stop_q <= 1'b0;
			mode_stop_q <= 1'b0;
		end else if (ctl.feed) begin
			if (in_mode && !mode_stop_q) begin
				if (is_term)
					mode_stop_q <= 1'b1;
				else
					mode_q <= mode_next;
			end
			if (in_size && !size_stop_q) begin
				if (is_term)
					size_stop_q <= 1'b1;
				else
					size_q <= size_next;
			end
			if (ctl.pos == TYPE_POS)
				type_q <= data;
		end
	end

	assign size_acc  = size_q;
	assign mode_acc  = mode_q;
	assign type_byte = type_q;

endmodule
`default_nettype wire

### hdl/tar_stream_deframer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tar_stream_deframer_core
// byte-serial tar archive deframer: labels each byte as header, file data,
// padding or after-end and reports decoded header fields
// ----------------------------------------------------------------------------
// One archive byte is taken per clock while in_stall is low, and each byte
// yields exactly one result, which reaches the outputs through the input
// register and then the result register. The block position counts
// every byte modulo 512 from reset. On byte 511 of a
// header, header_done rises with entry_kind, file_size and file_mode; a regular
// entry of nonzero size is followed by file_size data bytes and padding to the
// next 512-byte boundary. Two consecutive zero blocks end the archive, after
// which every byte is reported as region 3 with all flags cleared. The stall
// input holds the result register; in_stall rises only when the input
// register is full and the result register cannot advance.
module tar_stream_deframer_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [tsd_pkg::BYTE_W-1:0] data_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [tsd_pkg::BYTE_W-1:0] byte_out,
	output logic      [1:0]                 region,
	output logic      [tsd_pkg::POS_W-1:0]  block_offset,
	output logic                            header_done,
	output logic      [tsd_pkg::KIND_W-1:0] entry_kind,
	output logic      [tsd_pkg::SIZE_W-1:0] file_size,
	output logic      [tsd_pkg::MODE_W-1:0] file_mode,
	output logic                            data_last,
	output logic                            archive_end
);
	import tsd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              advance;
	logic              fire;

	region_t           region_q;
	logic [POS_W-1:0]  pos_q;
	logic [SIZE_W-1:0] remain_q;
	logic [POS_W-1:0]  pad_q;
	logic [ZCNT_W-1:0] zcount_q;

	hdr_ctl_t          hdr_ctl;
	logic [SIZE_W-1:0] size_acc;
	logic [MODE_W-1:0] mode_acc;
	logic [BYTE_W-1:0] type_byte;

	logic              is_hdr;
	logic              at_last;
	logic              hdr_done_c;
	logic              zero_type;
	logic              end_c;
	logic              last_c;

	logic [BYTE_W-1:0] byte_s2;
	logic [1:0]        region_s2;
	logic [POS_W-1:0]  pos_s2;
	logic              hdr_done_s2;
	logic [KIND_W-1:0] kind_s2;
	logic [SIZE_W-1:0] size_s2;
	logic [MODE_W-1:0] mode_s2;
	logic              last_s2;
	logic              end_s2;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_comb begin
		is_hdr      = (region_q == RGN_HEADER);
		at_last     = (pos_q == BLOCK_LAST);
		hdr_done_c  = is_hdr && at_last;
		zero_type   = (type_byte == CHAR_NUL);
		end_c       = hdr_done_c && zero_type && (zcount_q != '0);
		last_c      = (region_q == RGN_DATA) && (remain_q <= SIZE_W'(1));
		hdr_ctl.feed  = fire && is_hdr;
		hdr_ctl.clear = fire && hdr_done_c;
		hdr_ctl.pos   = pos_q;
	end

	tsd_hdr_fields u_hdr_fields (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hdr_ctl),
		.data      (byte_s1),
		.size_acc  (size_acc),
		.mode_acc  (mode_acc),
		.type_byte (type_byte)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// deframing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			region_q    <= RGN_HEADER;
			pos_q       <= '0;
			remain_q    <= '0;
			pad_q       <= '0;
			zcount_q    <= '0;
		end else begin
			if (advance)
				out_valid_q <= valid_s1;
			if (fire) begin
				pos_q <= pos_q + POS_W'(1);
				case (region_q)
					RGN_HEADER: begin
						if (at_last) begin
							if (zero_type) begin
								if (zcount_q < ZERO_BLOCKS_TO_END)
									zcount_q <= zcount_q + ZCNT_W'(1);
								if (end_c)
									region_q <= RGN_END;
							end else begin
								zcount_q <= '0;
								if (type_byte == CHAR_ZERO && size_acc != '0) begin
									remain_q <= size_acc;
									pad_q    <= -size_acc[POS_W-1:0];
									region_q <= RGN_DATA;
								end
							end
						end
					end
					RGN_DATA: begin
						if (last_c) begin
							remain_q <= '0;
							region_q <= (pad_q != '0) ? RGN_PAD : RGN_HEADER;
						end else begin
							remain_q <= remain_q - SIZE_W'(1);
						end
					end
					RGN_PAD: begin
						if (pad_q <= POS_W'(1)) begin
							pad_q    <= '0;
							region_q <= RGN_HEADER;
						end else begin
							pad_q <= pad_q - POS_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			byte_s2     <= byte_s1;
			region_s2   <= region_q;
			pos_s2      <= pos_q;
			hdr_done_s2 <= hdr_done_c;
			kind_s2     <= hdr_done_c ? kind_of(type_byte) : KIND_ZERO_BLOCK;
			size_s2     <= hdr_done_c ? size_acc : '0;
			mode_s2     <= hdr_done_c ? mode_acc : '0;
			last_s2     <= last_c;
			end_s2      <= end_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_out     = byte_s2;
	assign region       = region_s2;
	assign block_offset = pos_s2;
	assign header_done  = hdr_done_s2;
	assign entry_kind   = kind_s2;
	assign file_size    = size_s2;
	assign file_mode    = mode_s2;
	assign data_last    = last_s2;
	assign archive_end  = end_s2;

endmodule
`default_nettype wire
